>>> rtl/core/ett_pkg.sv
// Shared types, constants and codes for the exponential trace table.
// No dependencies; used by every module of the block except ett_ram.
package ett_pkg;

    localparam int TRACE_COUNT_DEF = 256;

    localparam logic [15:0] DECAY_RESET  = 16'd65209;
    localparam logic [23:0] INVTAU_RESET = 24'd204800;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN      = 32'h8000_0000;

    localparam logic [0:0] CFG_DECAY  = 1'b0;
    localparam logic [0:0] CFG_INVTAU = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_INC  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SET  = 3'd3,
        OP_CLIP = 3'd4,
        OP_READ = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  idx;
        logic [31:0] val;
        logic        ok;
    } ett_item_t;

    typedef struct packed {
        logic init_done;
        logic pop;
    } ett_status_t;

endpackage

>>> rtl/core/ett_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ett_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ett_front.sv
// Front end: accepts input beats, drops no-op items, queues the rest.
// Depends on ett_pkg.
module ett_front #(
    parameter int TRACE_COUNT = ett_pkg::TRACE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // entry_index[7:0], operand_value[39:8]
    input  logic [2:0]          s_axis_tuser,   // operation[2:0]
    output ett_pkg::ett_item_t  head,
    output logic                head_valid,
    input  ett_pkg::ett_status_t status
);
    import ett_pkg::*;

    localparam logic [16:0] COUNT = 17'(TRACE_COUNT);

    ett_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    ett_item_t  in_item;
    logic       keep;
    logic       push;

    always_comb
    begin
        in_item.op  = op_t'(s_axis_tuser);
        in_item.idx = s_axis_tdata[7:0];
        in_item.val = s_axis_tdata[39:8];
        in_item.ok  = ({9'b0, s_axis_tdata[7:0]} < COUNT);
        case (in_item.op)
            OP_TICK, OP_CLIP, OP_READ: keep = 1'b1;
            OP_INC, OP_ADD, OP_SET:    keep = in_item.ok;
            default:                   keep = 1'b0;
        endcase
    end

    assign s_axis_tready = status.init_done && (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready && keep;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = status.pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, status.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

endmodule

>>> rtl/core/ett_back.sv
// Back end: clearing pass, sweep/single-entry pipeline over the trace RAM,
// result register. Depends on ett_pkg and ett_ram.
module ett_back #(
    parameter int TRACE_COUNT = ett_pkg::TRACE_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ett_pkg::ett_item_t   head,
    input  logic                 head_valid,
    output ett_pkg::ett_status_t status,
    input  logic [15:0]          decay_factor,
    input  logic [23:0]          inverse_tau,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata   // read_index[7:0], normalized_trace[39:8]
);
    import ett_pkg::*;

    localparam int AW = (TRACE_COUNT > 1) ? $clog2(TRACE_COUNT) : 1;
    localparam int CW = $clog2(TRACE_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(TRACE_COUNT - 1);
    localparam logic [CW-1:0] NUM  = CW'(TRACE_COUNT);

    back_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    ett_item_t     cur_reg;
    logic          load;
    logic          pop;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [55:0]   s2_prod_reg;
    logic          s2_neg_reg;
    logic [31:0]   s2_data_reg;
    logic [32:0]   s2_sum_reg;

    logic          out_valid_reg, out_valid_next;
    logic [39:0]   out_data_reg;

    logic [AW+7:0] idx_wide;
    logic [AW-1:0] idx_addr;
    logic          sweep;
    logic [CW-1:0] n_reads;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rdata;
    logic          clr_we;

    logic [31:0]   d1;
    logic          neg1;
    logic [31:0]   mag1;
    logic [23:0]   factor;
    logic [55:0]   prod1;
    logic [31:0]   addend;
    logic [32:0]   sum1;

    logic [43:0]   p44;
    logic [31:0]   scaled;
    logic [31:0]   sat_sum;
    logic [31:0]   clipped;
    logic [31:0]   s2_wdata;
    logic          s2_we;
    logic          out_load;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;

    assign idx_wide = {{AW{1'b0}}, cur_reg.idx};
    assign idx_addr = idx_wide[AW-1:0];
    assign sweep    = (cur_reg.op == OP_TICK) || (cur_reg.op == OP_CLIP);
    assign n_reads  = sweep ? NUM : CW'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load       = 1'b0;
        pop        = 1'b0;
        rd_en      = 1'b0;
        clr_we     = 1'b0;
        rd_addr    = sweep ? cnt_reg[AW-1:0] : idx_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (head_valid && ((head.op != OP_READ) || !out_valid_reg))
                begin
                    pop        = 1'b1;
                    load       = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != n_reads)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (!s1_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= rd_en;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 1: RAM data in, one multiply and one add in parallel
    always_comb
    begin
        d1     = (cur_reg.ok || sweep) ? rdata : 32'd0;
        neg1   = d1[31];
        mag1   = neg1 ? (32'd0 - d1) : d1;
        factor = (cur_reg.op == OP_READ) ? inverse_tau : {8'd0, decay_factor};
        prod1  = 56'(mag1) * 56'(factor);
        addend = (cur_reg.op == OP_INC) ? ONE_Q16 : cur_reg.val;
        sum1   = {d1[31], d1} + {addend[31], addend};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= head;
        end
        if (rd_en)
        begin
            s1_addr_reg <= rd_addr;
        end
        if (s1_valid_reg)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_prod_reg <= prod1;
            s2_neg_reg  <= neg1;
            s2_data_reg <= d1;
            s2_sum_reg  <= sum1;
        end
    end

    // stage 2: shift, saturate, clip, write back or hand to the result register
    always_comb
    begin
        p44 = (cur_reg.op == OP_READ) ? s2_prod_reg[55:12] : {4'd0, s2_prod_reg[55:16]};
        if (s2_neg_reg)
        begin
            scaled = (p44 > 44'h0_8000_0000) ? S32_MIN : (32'd0 - p44[31:0]);
        end
        else
        begin
            scaled = (p44 > 44'h0_7FFF_FFFF) ? S32_MAX : p44[31:0];
        end

        if (s2_sum_reg[32] != s2_sum_reg[31])
        begin
            sat_sum = s2_sum_reg[32] ? S32_MIN : S32_MAX;
        end
        else
        begin
            sat_sum = s2_sum_reg[31:0];
        end

        if (s2_data_reg[31])
        begin
            clipped = 32'd0;
        end
        else if ($signed(s2_data_reg) > $signed(cur_reg.val))
        begin
            clipped = cur_reg.val;
        end
        else
        begin
            clipped = s2_data_reg;
        end

        s2_we    = 1'b0;
        out_load = 1'b0;
        s2_wdata = scaled;
        case (cur_reg.op)
            OP_TICK:
            begin
                s2_we = s2_valid_reg;
            end
            OP_INC, OP_ADD:
            begin
                s2_we    = s2_valid_reg;
                s2_wdata = sat_sum;
            end
            OP_SET:
            begin
                s2_we    = s2_valid_reg;
                s2_wdata = cur_reg.val;
            end
            OP_CLIP:
            begin
                s2_we    = s2_valid_reg;
                s2_wdata = clipped;
            end
            OP_READ:
            begin
                out_load = s2_valid_reg;
            end
            default:
            begin
                s2_we = 1'b0;
            end
        endcase
    end

    assign ram_we    = clr_we || s2_we;
    assign ram_waddr = clr_we ? cnt_reg[AW-1:0] : s2_addr_reg;
    assign ram_wdata = clr_we ? 32'd0 : s2_wdata;

    ett_ram #(
        .WIDTH (32),
        .DEPTH (TRACE_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {scaled, cur_reg.idx};
        end
    end

    assign m_axis_tvalid    = out_valid_reg;
    assign m_axis_tdata     = out_data_reg;
    assign status.init_done = (state_reg != ST_CLEAR);
    assign status.pop       = pop;

endmodule

>>> rtl/core/exponential_trace_table_unit.sv
// Exponential trace table, top level: configuration registers, front queue, back end.
// Increment, add, set and read each pass through a single RAM read, stage 1 and stage 2;
// a read result then goes to the result register. Tick and clip sweep the RAM, one entry a cycle.
// Throughput is set by the back end's single RAM read/write pipeline.
// After reset a clearing pass zeroes every entry of the table, s_axis_tready low.
// Depends on ett_pkg, ett_front, ett_back, ett_ram.
module exponential_trace_table_unit #(
    parameter int TRACE_COUNT = ett_pkg::TRACE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // entry_index[7:0], operand_value[39:8]
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_index[7:0], normalized_trace[39:8]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import ett_pkg::*;

    logic [15:0] decay_reg;
    logic [23:0] invtau_reg;
    ett_item_t   head;
    logic        head_valid;
    ett_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            invtau_reg <= INVTAU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECAY:  decay_reg  <= cfg_data[15:0];
                CFG_INVTAU: invtau_reg <= cfg_data;
                default:    decay_reg  <= decay_reg;
            endcase
        end
    end

    ett_front #(
        .TRACE_COUNT (TRACE_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .head_valid    (head_valid),
        .status        (status)
    );

    ett_back #(
        .TRACE_COUNT (TRACE_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .status        (status),
        .decay_factor  (decay_reg),
        .inverse_tau   (invtau_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/core/ett_checker.sv
// Port-level checker for the exponential trace table, bound to the top level.
// Depends on ett_pkg.
module ett_checker #(
    parameter int TRACE_COUNT = ett_pkg::TRACE_COUNT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    localparam logic [16:0] COUNT = 17'(TRACE_COUNT);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input beat withdrawn or changed while waiting");

    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ({9'b0, m_axis_tdata[7:0]} >= COUNT) |-> m_axis_tdata[39:8] == 32'd0)
        else $error("read beyond table returned non-zero");

endmodule

bind exponential_trace_table_unit ett_checker #(.TRACE_COUNT(TRACE_COUNT)) u_ett_checker (.*);
